// ===== rtl/core/sm4_pkg.sv =====
// Package with SM4 types, constants and round functions.
package sm4_pkg;

  localparam int NumRounds = 32;
  localparam int RoundIdxW = 5;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } sm4_in_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } sm4_out_t;

  typedef enum logic [0:0] {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } sm4_cfg_idx_t;

  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] tau(input logic [31:0] a);
    tau = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
  endfunction

  // Round constant: byte j of CK[i] is (4*i+j)*7 mod 256.
  function automatic logic [31:0] round_const(input logic [RoundIdxW-1:0] i);
    logic [7:0] base;
    base = {1'b0, i, 2'b00} * 8'd7;
    round_const = {base, base + 8'd7, base + 8'd14, base + 8'd21};
  endfunction

endpackage

// ===== rtl/core/sm4_block_encrypt_top.sv =====
// Top level of the SM4 encryption pipeline built from a chain of round cells.
// Usage:
// An item (a 128-bit plaintext block) enters on in_valid/in_stall and is
// accepted at a clock edge where in_valid is high and in_stall is low. The
// key is held in two 64-bit registers written through cfg_we/cfg_idx/cfg_data
// (index 0 is the upper key half, index 1 the lower half); write them only
// while the block is idle. The key travels with each item down the chain so
// every cell expands its own round key.
// The chain has 32 cells, one SM4 round each; an accepted item passes through
// the register of every cell in turn before it leaves on out_valid.
// Throughput is one item per cycle unless stalled. Each cell holds one item,
// so the whole chain advances together: when out_stall is high with a
// finished item at the end, every cell holds and in_stall is raised for that
// cycle. Empty slots inside the chain are not squeezed out; they move with it.
// Reset (synchronous, active low) empties the chain and clears both key
// registers to zero.
module sm4_block_encrypt_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_idx,
  input  logic [63:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  sm4_pkg::sm4_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sm4_pkg::sm4_out_t out_data
);
  import sm4_pkg::*;

  logic [63:0] key_high_r, key_low_r;
  logic        adv;
  logic        vld   [NumRounds+1];
  logic [127:0] kk   [NumRounds+1];
  logic [127:0] xx   [NumRounds+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_KEY_HIGH: key_high_r <= cfg_data;
        CFG_KEY_LOW:  key_low_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The chain moves whenever the last cell is empty or being drained.
  assign adv      = !vld[NumRounds] || !out_stall;
  assign in_stall = !adv;

  assign vld[0] = in_valid;
  assign kk[0]  = {key_high_r[63:32] ^ FK0, key_high_r[31:0] ^ FK1,
                   key_low_r[63:32] ^ FK2, key_low_r[31:0] ^ FK3};
  assign xx[0]  = {in_data.plain_high, in_data.plain_low};

  for (genvar g = 0; g < NumRounds; g++) begin : g_cell
    sm4_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .round_idx (RoundIdxW'(g)),
      .vld_in    (vld[g]),
      .k_in      (kk[g]),
      .x_in      (xx[g]),
      .vld_out   (vld[g+1]),
      .k_out     (kk[g+1]),
      .x_out     (xx[g+1])
    );
  end

  // Output is the final four words in reverse order.
  assign out_valid            = vld[NumRounds];
  assign out_data.cipher_high = {xx[NumRounds][31:0], xx[NumRounds][63:32]};
  assign out_data.cipher_low  = {xx[NumRounds][95:64], xx[NumRounds][127:96]};

  // A stalled result must not be lost or changed.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Input is refused only when the end of the chain is full and stalled.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // Reset leaves the chain empty, so no result is offered right after it.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");
endmodule

// ===== rtl/core/sm4_cell.sv =====
// One SM4 pipeline cell: one key-schedule round and one cipher round.
module sm4_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic [sm4_pkg::RoundIdxW-1:0]  round_idx,
  input  logic                           vld_in,
  input  logic [127:0]                   k_in,
  input  logic [127:0]                   x_in,
  output logic                           vld_out,
  output logic [127:0]                   k_out,
  output logic [127:0]                   x_out
);
  import sm4_pkg::*;

  logic [31:0] kb, rk, xb, xn;
  logic        vld_r;
  logic [127:0] k_r, x_r;

  always_comb begin
    kb = tau(k_in[95:64] ^ k_in[63:32] ^ k_in[31:0] ^ round_const(round_idx));
    rk = k_in[127:96] ^ kb ^ rotl(kb, 13) ^ rotl(kb, 23);
    xb = tau(x_in[95:64] ^ x_in[63:32] ^ x_in[31:0] ^ rk);
    xn = x_in[127:96] ^ xb ^ rotl(xb, 2) ^ rotl(xb, 10) ^ rotl(xb, 18) ^ rotl(xb, 24);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_r <= {k_in[95:0], rk};
      x_r <= {x_in[95:0], xn};
    end
  end

  assign vld_out = vld_r;
  assign k_out   = k_r;
  assign x_out   = x_r;
endmodule

// ===== tb/tb_sm4_block_encrypt_top.sv =====
// Self-checking testbench for the SM4 block encryption pipeline.
module tb_sm4_block_encrypt_top;
  import sm4_pkg::*;

  // Number of cells in the round chain.
  localparam int ChainDepth = 32;
  localparam int StallLimit = 4000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [0:0] cfg_idx;
  logic [63:0] cfg_data;
  logic in_valid;
  logic in_stall;
  sm4_in_t in_data;
  logic out_valid;
  logic out_stall;
  sm4_out_t out_data;

  sm4_block_encrypt_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // The testbench keeps its own copy of the key registers.
  logic [63:0] key_hi_shadow;
  logic [63:0] key_lo_shadow;

  sm4_out_t cipher_queue[$];
  int mismatches;
  int blocks_sent;
  int blocks_checked;
  int idle_cycles;
  int key_settings;
  // When set, both sides stop idling for the final part of the run.
  bit no_idle;

  // Byte substitution table, taken from the standard.
  localparam logic [7:0] SubBytes [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // Substitute each byte of a word; mix_round or mix_key then mixes it.
  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SubBytes[w[31:24]], SubBytes[w[23:16]], SubBytes[w[15:8]], SubBytes[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_round(input logic [31:0] b);
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^ {b[13:0], b[31:14]}
             ^ {b[7:0], b[31:8]};
  endfunction

  function automatic logic [31:0] mix_key(input logic [31:0] b);
    return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  endfunction

  // Full encryption of one block under the shadow key.
  function automatic sm4_out_t predict_cipher(input sm4_in_t blk);
    logic [31:0] kw[4];
    logic [31:0] xw[4];
    logic [31:0] rkey;
    logic [31:0] ck;
    logic [7:0] cb;
    sm4_out_t res;
    ck = '0;
    kw[0] = key_hi_shadow[63:32] ^ 32'ha3b1bac6;
    kw[1] = key_hi_shadow[31:0] ^ 32'h56aa3350;
    kw[2] = key_lo_shadow[63:32] ^ 32'h677d9197;
    kw[3] = key_lo_shadow[31:0] ^ 32'hb27022dc;
    xw[0] = blk.plain_high[63:32];
    xw[1] = blk.plain_high[31:0];
    xw[2] = blk.plain_low[63:32];
    xw[3] = blk.plain_low[31:0];
    for (int r = 0; r < 32; r++) begin
      for (int j = 0; j < 4; j++) begin
        cb = 8'((4 * r + j) * 7);
        ck = {ck[23:0], cb};
      end
      rkey = kw[0] ^ mix_key(sub_word(kw[1] ^ kw[2] ^ kw[3] ^ ck));
      kw[0] = kw[1]; kw[1] = kw[2]; kw[2] = kw[3]; kw[3] = rkey;
      rkey = xw[0] ^ mix_round(sub_word(xw[1] ^ xw[2] ^ xw[3] ^ rkey));
      xw[0] = xw[1]; xw[1] = xw[2]; xw[2] = xw[3]; xw[3] = rkey;
    end
    res.cipher_high = {xw[3], xw[2]};
    res.cipher_low = {xw[1], xw[0]};
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  // Output side: random stall bursts, checking every accepted item.
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cipher_queue.size() == 0) begin
          report_mismatch("unexpected item", out_data.cipher_high, 64'h0);
        end else begin
          sm4_out_t want;
          want = cipher_queue.pop_front();
          if (out_data.cipher_high !== want.cipher_high)
            report_mismatch("cipher_high", out_data.cipher_high, want.cipher_high);
          if (out_data.cipher_low !== want.cipher_low)
            report_mismatch("cipher_low", out_data.cipher_low, want.cipher_low);
          blocks_checked++;
        end
      end
      // Decide the stall for the next cycle, continuing a burst or starting a random one.
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: counts cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("[sm4_block_encrypt_top] ERROR");
        $finish;
      end
    end
  end

  // Send one block, with an optional random idle burst ahead of it. The
  // prediction is made at acceptance, under the key in force then.
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    sm4_in_t blk;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    blk.plain_high = hi;
    blk.plain_low = lo;
    in_data <= blk;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cipher_queue.push_back(predict_cipher(blk));
    blocks_sent++;
  endtask

  // Wait until the pipeline has delivered everything, then let it settle.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cipher_queue.size() != 0) @(posedge clk);
    repeat (ChainDepth + 4) @(posedge clk);
  endtask

  // One register write; the enable is low again before the task returns.
  task automatic write_key(input sm4_cfg_idx_t idx, input logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_KEY_HIGH) key_hi_shadow = value;
    else key_lo_shadow = value;
    @(posedge clk);
  endtask

  task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
    drain_pipeline();
    write_key(CFG_KEY_HIGH, hi);
    write_key(CFG_KEY_LOW, lo);
    key_settings++;
  endtask

  // Blocks encrypted under the all-zero key left by reset.
  task automatic test_reset_key();
    send_block(64'h0, 64'h0);
    send_block('1, '1);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
  endtask

  // The standard vector, walking bits, and all-ones halves so every input bit toggles.
  task automatic test_standard_vector();
    set_key(64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
    for (int b = 0; b < 64; b += 9)
      send_block(64'h1 << b, ~(64'h1 << b));
    send_block('1, 64'h0);
    send_block(64'h0, '1);
  endtask

  // Extreme keys; each half is written separately so one half changes alone.
  task automatic test_key_extremes();
    set_key('1, '1);
    send_block(64'h0, 64'h0);
    send_block('1, '1);
    drain_pipeline();
    write_key(CFG_KEY_LOW, 64'h0);
    send_block(64'h8000000000000001, 64'h8000000000000001);
    drain_pipeline();
    write_key(CFG_KEY_HIGH, 64'h0);
    send_block(64'h0123456789abcdef, 64'h0);
  endtask

  // Random blocks under a few random keys; the sender holds off once mid-run.
  task automatic test_random_blocks(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 200 == 0)
        set_key({$urandom, $urandom}, {$urandom, $urandom});
      if (n == 350) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (cipher_queue.size() != 0) @(posedge clk);
      end
      // The final stretch runs without idling on either side.
      if (n == count - 150) no_idle = 1'b1;
      send_block({$urandom, $urandom}, {$urandom, $urandom});
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_KEY_HIGH;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    mismatches = 0;
    blocks_sent = 0;
    blocks_checked = 0;
    key_settings = 0;
    no_idle = 1'b0;
    key_hi_shadow = '0;
    key_lo_shadow = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_key();
    test_standard_vector();
    test_key_extremes();
    test_random_blocks(900);
    drain_pipeline();

    $display("Encrypted %0d blocks under %0d key settings, %0d results checked.",
             blocks_sent, key_settings, blocks_checked);
    if (mismatches == 0 && cipher_queue.size() == 0) begin
      $display("[sm4_block_encrypt_top] OK");
    end else begin
      $display("[sm4_block_encrypt_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== sm4_block_encrypt_top.f =====
rtl/core/sm4_pkg.sv
rtl/core/sm4_cell.sv
rtl/core/sm4_block_encrypt_top.sv
tb/tb_sm4_block_encrypt_top.sv
